### rtl/core/two_pool_memory_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef TWO_POOL_MEMORY_ALLOCATOR_DEFINES_SVH
`define TWO_POOL_MEMORY_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TPMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TPMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tpma_pkg.sv
// Shared constants and types of the two-pool memory allocator.
// No dependencies; imported by the allocator top level.
`timescale 1ns / 1ps

package tpma_pkg;

  localparam int ADDR_BITS  = 20;
  localparam int UNIT_BYTES = 32;
  localparam int NODE_BYTES = 4;
  localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int NODE_SHIFT = $clog2(NODE_BYTES);
  localparam int UIDX_W     = ADDR_BITS - UNIT_SHIFT;
  localparam int UNIT_DIV   = NODE_BYTES + UNIT_BYTES;

  // The unit count half / 36 is taken as (half >> 2) / 9 with a reciprocal
  // multiply, which is exact over the whole address range.
  localparam int DIV_PRE   = 2;
  localparam int DIV_ODD   = UNIT_DIV >> DIV_PRE;
  localparam int DIV_POST  = ADDR_BITS + 1;
  localparam int DIV_MUL   = (2**DIV_POST + DIV_ODD - 1) / DIV_ODD;
  localparam int DIV_MUL_W = $clog2(DIV_MUL + 1);

  localparam int CFG_W       = 21;
  localparam int HDR_W       = 7;
  localparam int TOTAL_MIN   = 72;
  localparam int TOTAL_MAX   = 1048576;
  localparam int TOTAL_RESET = 65536;
  localparam int HDR_MIN     = 8;
  localparam int HDR_MAX     = 64;
  localparam int HDR_RESET   = 20;

  typedef enum logic [0:0] {
    CFG_TOTAL  = 1'b0,
    CFG_HEADER = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    addr_t start;
    addr_t used;
    addr_t spare;
  } seg_t;

endpackage

### rtl/core/two_pool_memory_allocator.sv
// Two-pool allocator: one request beat in, one status beat out. Unit-pool allocs and frees
// pop and push a linked free list of units; a heap request walks the segment table through
// the read port of its segment RAM, one entry per cycle, and then moves the entries behind
// the affected one, one per cycle. Scanned and moved entries together never exceed the
// segment count. After reset and after each total_size write the block rebuilds and holds
// in_stall_o high meanwhile. Depends on tpma_pkg, tpma_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "two_pool_memory_allocator_defines.svh"

module two_pool_memory_allocator import tpma_pkg::*; #(
  parameter int FIXED_UNITS = 1024,
  parameter int SEGMENTS    = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  input  logic [ADDR_BITS-1:0] request_size_i,
  input  logic [ADDR_BITS-1:0] free_address_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic                 pool_o,
  output logic [ADDR_BITS-1:0] address_o
);

  localparam int UIW  = (FIXED_UNITS > 1) ? $clog2(FIXED_UNITS) : 1;
  localparam int UW   = $clog2(FIXED_UNITS + 1);
  localparam int SW   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int SCW  = $clog2(SEGMENTS + 1);
  localparam int QX_W = ADDR_BITS - DIV_PRE;
  localparam int QP_W = QX_W + DIV_MUL_W;
  localparam int QN_W = QP_W - DIV_POST;
  localparam logic [UW-1:0] UNIT_EMPTY = UW'(FIXED_UNITS);

  typedef enum logic [13:0] {
    S_INIT   = 14'h0001,
    S_IDLE   = 14'h0002,
    S_UPOP   = 14'h0004,
    S_UCHK   = 14'h0008,
    S_UFREE  = 14'h0010,
    S_SCAN   = 14'h0020,
    S_AC1    = 14'h0040,
    S_AC2    = 14'h0080,
    S_ASHIFT = 14'h0100,
    S_ANEW   = 14'h0200,
    S_FC1    = 14'h0400,
    S_FC2    = 14'h0800,
    S_FSHIFT = 14'h1000,
    S_OUT    = 14'h2000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]     total_q, total_d;
  logic [HDR_W-1:0]     header_q, header_d;
  logic [HDR_W-1:0]     hdr_q, hdr_d;
  logic [UW-1:0]        unit_total_q, unit_total_d;
  logic [UW-1:0]        head_q, head_d;
  logic [UW-1:0]        fresh_q, fresh_d;
  logic [SCW-1:0]       seg_cnt_q, seg_cnt_d;
  logic                 mode_q, mode_d;
  addr_t                size_q, size_d;
  addr_t                faddr_q, faddr_d;
  logic [ADDR_BITS:0]   need_q, need_d;
  logic [SCW-1:0]       scan_q, scan_d;
  logic                 dv_q, dv_d;
  logic [SCW-1:0]       di_q, di_d;
  logic [SCW-1:0]       fi_q, fi_d;
  seg_t                 cur_q, cur_d;
  seg_t                 prev_q, prev_d;
  addr_t                acc_q, acc_d;
  logic                 uok_q, uok_d;
  logic [UIW-1:0]       uidx_q, uidx_d;
  logic [1:0]           res_status_q, res_status_d;
  logic                 res_pool_q, res_pool_d;
  addr_t                res_addr_q, res_addr_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           status_q, status_d;
  logic                 pool_q, pool_d;
  addr_t                address_q, address_d;

  // Memory ports.
  logic           link_we;
  logic [UIW-1:0] link_waddr, link_raddr;
  logic [UW-1:0]  link_wdata, link_rdata;
  logic           used_we;
  logic [UIW-1:0] used_waddr, used_raddr;
  logic           used_wdata, used_rdata;
  logic           seg_we;
  logic [SW-1:0]  seg_waddr, seg_raddr;
  seg_t           seg_wdata, seg_rdata;

  // Rebuild and unit-area helpers.
  addr_t              half_w, spare0_w, ubase_w, uoff_w, unit_addr_w;
  logic [CFG_W-1:0]   vsize_w, tot_sat_w;
  logic [HDR_W-1:0]   hdr_sat_w;
  logic [QX_W-1:0]    qx_w;
  logic [QP_W-1:0]    qprod_w;
  logic [QN_W-1:0]    qn_w;
  logic [UIDX_W-1:0]  uidx_w;
  logic [UW-1:0]      hp1_w;
  logic               hit_w, issue_w, in_use_w;

  assign half_w   = total_q[CFG_W-1:1];
  assign vsize_w  = total_q - CFG_W'(half_w);
  assign spare0_w = (vsize_w > CFG_W'(hdr_q)) ? ADDR_BITS'(vsize_w - CFG_W'(hdr_q)) : '0;

  assign tot_sat_w = (cfg_data_i < CFG_W'(TOTAL_MIN)) ? CFG_W'(TOTAL_MIN) :
                     (cfg_data_i > CFG_W'(TOTAL_MAX)) ? CFG_W'(TOTAL_MAX) : cfg_data_i;
  assign hdr_sat_w = (cfg_data_i[HDR_W-1:0] < HDR_W'(HDR_MIN)) ? HDR_W'(HDR_MIN) :
                     (cfg_data_i[HDR_W-1:0] > HDR_W'(HDR_MAX)) ? HDR_W'(HDR_MAX) :
                     cfg_data_i[HDR_W-1:0];

  // Unit count half / (node + unit bytes) by a reciprocal multiply.
  assign qx_w    = half_w[ADDR_BITS-1:DIV_PRE];
  assign qprod_w = QP_W'(qx_w) * QP_W'(DIV_MUL);
  assign qn_w    = qprod_w[QP_W-1:DIV_POST];

  assign ubase_w     = ADDR_BITS'(unit_total_q) << NODE_SHIFT;
  assign uoff_w      = faddr_q - ubase_w;
  assign uidx_w      = uoff_w[ADDR_BITS-1:UNIT_SHIFT];
  assign unit_addr_w = ubase_w + (ADDR_BITS'(head_q) << UNIT_SHIFT);
  assign hp1_w       = head_q + UW'(1);
  // Units at or above the fresh mark were never handed out since the last rebuild.
  assign in_use_w    = (UW'(uidx_q) < fresh_q) && used_rdata;

  assign issue_w = (state_q == S_FSHIFT) ? (scan_q < seg_cnt_q) :
                   (state_q == S_ASHIFT) ? (scan_q > fi_q) : (scan_q < seg_cnt_q);
  assign hit_w   = (mode_q == MODE_ALLOC) ?
                   ({1'b0, seg_rdata.spare} >= need_q) :
                   (ADDR_BITS'(seg_rdata.start + ADDR_BITS'(hdr_q)) == faddr_q);

  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    header_d     = header_q;
    hdr_d        = hdr_q;
    unit_total_d = unit_total_q;
    head_d       = head_q;
    fresh_d      = fresh_q;
    seg_cnt_d    = seg_cnt_q;
    mode_d       = mode_q;
    size_d       = size_q;
    faddr_d      = faddr_q;
    need_d       = need_q;
    scan_d       = scan_q;
    dv_d         = dv_q;
    di_d         = di_q;
    fi_d         = fi_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    acc_d        = acc_q;
    uok_d        = uok_q;
    uidx_d       = uidx_q;
    res_status_d = res_status_q;
    res_pool_d   = res_pool_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q & out_stall_i;
    status_d     = status_q;
    pool_d       = pool_q;
    address_d    = address_q;

    link_we    = 1'b0;
    link_waddr = uidx_q;
    link_wdata = head_q;
    link_raddr = head_q[UIW-1:0];
    used_we    = 1'b0;
    used_waddr = head_q[UIW-1:0];
    used_wdata = 1'b1;
    used_raddr = uidx_w[UIW-1:0];
    seg_we     = 1'b0;
    seg_waddr  = fi_q[SW-1:0];
    seg_wdata  = cur_q;
    seg_raddr  = scan_q[SW-1:0];

    case (state_q)
      S_INIT: begin
        unit_total_d = (qn_w > QN_W'(FIXED_UNITS)) ? UW'(FIXED_UNITS) : UW'(qn_w);
        head_d    = (qn_w != '0) ? '0 : UNIT_EMPTY;
        fresh_d   = '0;
        seg_cnt_d = SCW'(1);
        seg_we    = 1'b1;
        seg_waddr = '0;
        seg_wdata = '{start: half_w, used: '0, spare: spare0_w};
        state_d   = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          size_d  = request_size_i;
          faddr_d = free_address_i;
          need_d  = {1'b0, request_size_i} + (ADDR_BITS + 1)'(hdr_q);
          scan_d  = '0;
          dv_d    = 1'b0;
          if (mode_i == MODE_FREE) begin
            state_d = S_UCHK;
          end else if ((request_size_i <= ADDR_BITS'(UNIT_BYTES)) &&
                       (head_q < unit_total_q)) begin
            state_d = S_UPOP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_UPOP: begin
        if (head_q < fresh_q) begin
          head_d = link_rdata;
        end else begin
          head_d  = (hp1_w < unit_total_q) ? hp1_w : UNIT_EMPTY;
          fresh_d = fresh_q + UW'(1);
        end
        used_we      = 1'b1;
        res_status_d = ST_DONE;
        res_pool_d   = 1'b0;
        res_addr_d   = unit_addr_w;
        state_d      = S_OUT;
      end
      S_UCHK: begin
        uok_d   = (faddr_q >= ubase_w) && (uoff_w[UNIT_SHIFT-1:0] == '0) &&
                  (uidx_w < UIDX_W'(unit_total_q));
        uidx_d  = uidx_w[UIW-1:0];
        state_d = S_UFREE;
      end
      S_UFREE: begin
        if (uok_q && in_use_w) begin
          link_we      = 1'b1;
          used_we      = 1'b1;
          used_waddr   = uidx_q;
          used_wdata   = 1'b0;
          head_d       = UW'(uidx_q);
          res_status_d = ST_DONE;
          res_pool_d   = 1'b0;
          res_addr_d   = '0;
          state_d      = S_OUT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (dv_q && hit_w) begin
          cur_d = seg_rdata;
          fi_d  = di_q;
          dv_d  = 1'b0;
          if (mode_q == MODE_ALLOC) begin
            if (seg_cnt_q >= SCW'(SEGMENTS)) begin
              res_status_d = ST_FULL;
              res_pool_d   = 1'b0;
              res_addr_d   = '0;
              state_d      = S_OUT;
            end else begin
              state_d = S_AC1;
            end
          end else if (di_q == '0) begin
            // The base segment is never released.
            res_status_d = ST_NOTFOUND;
            res_pool_d   = 1'b0;
            res_addr_d   = '0;
            state_d      = S_OUT;
          end else begin
            state_d = S_FC1;
          end
        end else begin
          if (dv_q) begin
            prev_d = seg_rdata;
          end
          if (issue_w) begin
            scan_d = scan_q + SCW'(1);
            dv_d   = 1'b1;
            di_d   = scan_q;
          end else begin
            dv_d = 1'b0;
            if (!dv_q) begin
              res_status_d = (mode_q == MODE_ALLOC) ? ST_NOSPACE : ST_NOTFOUND;
              res_pool_d   = 1'b0;
              res_addr_d   = '0;
              state_d      = S_OUT;
            end
          end
        end
      end
      S_AC1: begin
        acc_d     = cur_q.start + cur_q.used;
        seg_we    = 1'b1;
        seg_wdata = '{start: cur_q.start, used: cur_q.used,
                      spare: cur_q.spare - ADDR_BITS'(need_q)};
        state_d   = S_AC2;
      end
      S_AC2: begin
        // New block sits at the top of the spare bytes of the fitting segment.
        acc_d   = acc_q + cur_q.spare - size_q;
        scan_d  = seg_cnt_q - SCW'(1);
        dv_d    = 1'b0;
        state_d = S_ASHIFT;
      end
      S_ASHIFT: begin
        if (dv_q) begin
          seg_we    = 1'b1;
          seg_waddr = SW'(di_q + SCW'(1));
          seg_wdata = seg_rdata;
        end
        if (issue_w) begin
          scan_d = scan_q - SCW'(1);
          dv_d   = 1'b1;
          di_d   = scan_q;
        end else begin
          dv_d = 1'b0;
          if (!dv_q) begin
            state_d = S_ANEW;
          end
        end
      end
      S_ANEW: begin
        seg_we       = 1'b1;
        seg_waddr    = SW'(fi_q + SCW'(1));
        seg_wdata    = '{start: acc_q, used: size_q, spare: '0};
        seg_cnt_d    = seg_cnt_q + SCW'(1);
        res_status_d = ST_DONE;
        res_pool_d   = 1'b1;
        res_addr_d   = acc_q + ADDR_BITS'(hdr_q);
        state_d      = S_OUT;
      end
      S_FC1: begin
        acc_d   = prev_q.spare + cur_q.used;
        state_d = S_FC2;
      end
      S_FC2: begin
        seg_we    = 1'b1;
        seg_waddr = SW'(fi_q - SCW'(1));
        seg_wdata = '{start: prev_q.start, used: prev_q.used,
                      spare: acc_q + cur_q.spare + ADDR_BITS'(hdr_q)};
        scan_d    = fi_q + SCW'(1);
        dv_d      = 1'b0;
        state_d   = S_FSHIFT;
      end
      S_FSHIFT: begin
        if (dv_q) begin
          seg_we    = 1'b1;
          seg_waddr = SW'(di_q - SCW'(1));
          seg_wdata = seg_rdata;
        end
        if (issue_w) begin
          scan_d = scan_q + SCW'(1);
          dv_d   = 1'b1;
          di_d   = scan_q;
        end else begin
          dv_d = 1'b0;
          if (!dv_q) begin
            seg_cnt_d    = seg_cnt_q - SCW'(1);
            res_status_d = ST_DONE;
            res_pool_d   = 1'b1;
            res_addr_d   = '0;
            state_d      = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          pool_d      = res_pool_q;
          address_d   = res_addr_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase

    if (cfg_we_i) begin
      if (cfg_index_i == CFG_TOTAL) begin
        total_d = tot_sat_w;
        hdr_d   = header_q;
        state_d = S_INIT;
      end else begin
        header_d = hdr_sat_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      total_q      <= CFG_W'(TOTAL_RESET);
      header_q     <= HDR_W'(HDR_RESET);
      hdr_q        <= HDR_W'(HDR_RESET);
      unit_total_q <= '0;
      head_q       <= UNIT_EMPTY;
      fresh_q      <= '0;
      seg_cnt_q    <= SCW'(1);
      dv_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      total_q      <= total_d;
      header_q     <= header_d;
      hdr_q        <= hdr_d;
      unit_total_q <= unit_total_d;
      head_q       <= head_d;
      fresh_q      <= fresh_d;
      seg_cnt_q    <= seg_cnt_d;
      dv_q         <= dv_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    size_q       <= size_d;
    faddr_q      <= faddr_d;
    need_q       <= need_d;
    scan_q       <= scan_d;
    di_q         <= di_d;
    fi_q         <= fi_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    acc_q        <= acc_d;
    uok_q        <= uok_d;
    uidx_q       <= uidx_d;
    res_status_q <= res_status_d;
    res_pool_q   <= res_pool_d;
    res_addr_q   <= res_addr_d;
    status_q     <= status_d;
    pool_q       <= pool_d;
    address_q    <= address_d;
  end

  tpma_ram #(.WIDTH(UW), .DEPTH(FIXED_UNITS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  tpma_ram #(.WIDTH(1), .DEPTH(FIXED_UNITS)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .raddr_i (used_raddr),
    .rdata_o (used_rdata)
  );

  tpma_ram #(.WIDTH($bits(seg_t)), .DEPTH(SEGMENTS)) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_waddr),
    .wdata_i (seg_wdata),
    .raddr_i (seg_raddr),
    .rdata_o (seg_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign pool_o      = pool_q;
  assign address_o   = address_q;

  `TPMA_ASSERT_NOW(a_seg_cnt_range, 1'b1, (seg_cnt_q != '0) && (seg_cnt_q <= SCW'(SEGMENTS)), "segment count out of range")
  `TPMA_ASSERT_NOW(a_unit_list_sane, state_q == S_IDLE, (fresh_q <= unit_total_q) && ((head_q < unit_total_q) || (head_q == UNIT_EMPTY)), "unit free list inconsistent")
  `TPMA_ASSERT_NEXT(a_result_loaded, (state_q == S_OUT) && (!out_valid_q || !out_stall_i) && !cfg_we_i, out_valid_q && (state_q == S_IDLE), "result beat not loaded")

endmodule

### rtl/core/tpma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the unit list and the segment table.
`timescale 1ns / 1ps

module tpma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
